>>> design/integer_field_scanner_core_macros.svh
// Assertion macros used by the integer field scanner back stage.
`ifndef INTEGER_FIELD_SCANNER_CORE_MACROS_SVH
`define INTEGER_FIELD_SCANNER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

>>> design/ifs_pkg.sv
// Shared types, constants and helpers of the integer field scanner.
package ifs_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_MAXW  = 2'd1;
    localparam logic [1:0] REG_RSIZE = 2'd2;

    // Conversion kinds that need special handling; other codes scan decimal.
    localparam logic [2:0] KIND_AUTO = 3'd1;
    localparam logic [2:0] KIND_HEX  = 3'd3;
    localparam logic [2:0] KIND_OCT  = 3'd4;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MATCH = 2'd1,
        ST_INPUT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } t_base;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] max_width;
        logic [1:0] result_size;
    } t_cfg;

    typedef struct packed {
        logic       eoi;
        logic       ws;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       x;
        logic       dig_valid;
        logic [5:0] digit;
    } t_char_class;

    typedef struct packed {
        t_status     status;
        logic        neg;
        logic        consumed;
        logic [15:0] count;
    } t_res_info;

    function automatic logic [63:0] size_mask(input logic [1:0] size);
        logic [63:0] m;
        case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00ff;
            SIZE_16: m = 64'h0000_0000_0000_ffff;
            SIZE_32: m = 64'h0000_0000_ffff_ffff;
            SIZE_64: m = 64'hffff_ffff_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

>>> design/ifs_fifo.sv
// Small register queue used between the scanner stages and at the result side.
module ifs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ifs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> design/ifs_front.sv
// Front stage: takes characters, classifies them and queues them for the scanner.
module ifs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_input,
    input  logic                 i_pop,
    output logic                 o_empty,
    output ifs_pkg::t_char_class o_class
);
    localparam int CLS_W = $bits(ifs_pkg::t_char_class);

    ifs_pkg::t_char_class w_class;
    logic [CLS_W-1:0]     w_q_data;

    always_comb begin
        w_class           = '0;
        w_class.eoi       = i_end_of_input;
        w_class.ws        = i_char_code inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
        w_class.plus      = (i_char_code == 8'h2b);
        w_class.minus     = (i_char_code == 8'h2d);
        w_class.zero      = (i_char_code == 8'h30);
        w_class.x         = (i_char_code == 8'h78) || (i_char_code == 8'h58);
        // Digit value as in base 36; the scanner checks it against its base.
        if (i_char_code inside {[8'h30:8'h39]}) begin
            w_class.dig_valid = 1'b1;
            w_class.digit     = 6'(i_char_code - 8'h30);
        end else if (i_char_code inside {[8'h61:8'h7a]}) begin
            w_class.dig_valid = 1'b1;
            w_class.digit     = 6'(i_char_code - 8'h57);
        end else if (i_char_code inside {[8'h41:8'h5a]}) begin
            w_class.dig_valid = 1'b1;
            w_class.digit     = 6'(i_char_code - 8'h37);
        end
    end

    ifs_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (ifs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_class),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_q_data),
        .o_empty (o_empty)
    );

    assign o_class = ifs_pkg::t_char_class'(w_q_data);

endmodule

>>> design/ifs_back.sv
// Back stage: field state machine, digit accumulation and the result queue.
`include "integer_field_scanner_core_macros.svh"

module ifs_back #(
    parameter int VALUE_BITS = ifs_pkg::VALUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ifs_pkg::t_cfg        i_cfg,
    input  logic                 i_q_empty,
    input  ifs_pkg::t_char_class i_class,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [1:0]           o_status,
    output logic [63:0]          o_value,
    output logic                 o_char_consumed,
    output logic [15:0]          o_chars_consumed
);
    localparam int INFO_W = $bits(ifs_pkg::t_res_info);
    localparam int RES_W  = INFO_W + VALUE_BITS;

    ifs_pkg::t_phase          r_phase, n_phase;
    ifs_pkg::t_base           r_base, n_base;
    logic                     r_neg, n_neg;
    logic [VALUE_BITS-1:0]    r_acc, n_acc;
    logic [9:0]               r_width, n_width;
    logic [15:0]              r_total, n_total;

    ifs_pkg::t_base           w_eff_base;
    ifs_pkg::t_base           w_kind_base;
    logic [5:0]               w_base_val;
    logic [VALUE_BITS-1:0]    w_acc_md;
    logic [9:0]               w_width_inc;
    logic [15:0]              w_total_inc;
    logic                     w_room_b;
    logic                     w_room_a;
    logic                     w_prefix;
    logic                     w_dig_ok;
    logic                     w_fire;
    logic                     w_oq_full;
    logic                     w_emit;
    ifs_pkg::t_status         w_status;
    logic                     w_cons;
    logic                     w_take;
    logic                     w_ws;
    logic                     w_digit;
    ifs_pkg::t_res_info       w_info;
    logic [RES_W-1:0]         w_res;
    logic [RES_W-1:0]         w_oq_data;
    ifs_pkg::t_res_info       w_out_info;
    logic [VALUE_BITS-1:0]    w_out_acc;
    logic [VALUE_BITS-1:0]    w_out_signed;

    // One queued character is handled per cycle while the result queue has room.
    assign w_fire  = !i_q_empty && !w_oq_full;
    assign o_q_pop = w_fire;

    always_comb begin
        case (i_cfg.kind)
            ifs_pkg::KIND_HEX: w_kind_base = ifs_pkg::BASE_HEX;
            ifs_pkg::KIND_OCT: w_kind_base = ifs_pkg::BASE_OCT;
            default:           w_kind_base = ifs_pkg::BASE_DEC;
        endcase
    end

    assign w_prefix = (i_cfg.kind == ifs_pkg::KIND_AUTO) || (i_cfg.kind == ifs_pkg::KIND_HEX);

    // The base is latched at the first non-space character; a lone leading
    // zero under auto base switches to octal.
    always_comb begin
        if (r_phase == ifs_pkg::PH_SKIP) begin
            w_eff_base = w_kind_base;
        end else if (r_phase == ifs_pkg::PH_ZERO && i_cfg.kind == ifs_pkg::KIND_AUTO) begin
            w_eff_base = ifs_pkg::BASE_OCT;
        end else begin
            w_eff_base = r_base;
        end
    end

    always_comb begin
        case (w_eff_base)
            ifs_pkg::BASE_HEX: w_base_val = 6'd16;
            ifs_pkg::BASE_OCT: w_base_val = 6'd8;
            default:           w_base_val = 6'd10;
        endcase
    end

    assign w_acc_md = ((w_eff_base == ifs_pkg::BASE_HEX) ? (r_acc << 4) : (r_acc << 3))
                    + ((w_eff_base == ifs_pkg::BASE_DEC) ? (r_acc << 1) : '0)
                    + VALUE_BITS'(i_class.digit);

    assign w_width_inc = (r_width == '1) ? r_width : r_width + 10'd1;
    assign w_total_inc = (r_total == '1) ? r_total : r_total + 16'd1;
    assign w_room_b    = (i_cfg.max_width == '0) || (r_width < i_cfg.max_width);
    assign w_room_a    = (i_cfg.max_width == '0) || (w_width_inc < i_cfg.max_width);
    assign w_dig_ok    = i_class.dig_valid && w_room_b && (i_class.digit < w_base_val);

    // Next state and field-end decision.
    always_comb begin
        n_phase  = r_phase;
        n_base   = r_base;
        n_neg    = r_neg;
        w_emit   = 1'b0;
        w_status = ifs_pkg::ST_OK;
        w_cons   = 1'b0;
        w_take   = 1'b0;
        w_ws     = 1'b0;
        w_digit  = 1'b0;
        if (i_class.eoi) begin
            w_emit = 1'b1;
            case (r_phase)
                ifs_pkg::PH_SKIP: w_status = ifs_pkg::ST_INPUT;
                ifs_pkg::PH_SIGN: w_status = ifs_pkg::ST_MATCH;
                default:          w_status = ifs_pkg::ST_OK;
            endcase
        end else if (r_phase == ifs_pkg::PH_SKIP && i_class.ws) begin
            w_ws = 1'b1;
        end else if (r_phase == ifs_pkg::PH_SKIP && (i_class.plus || i_class.minus)) begin
            n_base  = w_kind_base;
            n_neg   = i_class.minus;
            n_phase = ifs_pkg::PH_SIGN;
            w_take  = 1'b1;
            if (!w_room_a) begin
                w_emit   = 1'b1;
                w_status = ifs_pkg::ST_MATCH;
                w_cons   = 1'b1;
            end
        end else if (r_phase == ifs_pkg::PH_SKIP || r_phase == ifs_pkg::PH_SIGN) begin
            n_base = w_eff_base;
            if (w_room_b && w_prefix && i_class.zero) begin
                n_phase = ifs_pkg::PH_ZERO;
                w_take  = 1'b1;
                w_emit  = !w_room_a;
                w_cons  = 1'b1;
            end else if (w_dig_ok) begin
                n_phase = ifs_pkg::PH_DIGITS;
                w_digit = 1'b1;
                w_take  = 1'b1;
                w_emit  = !w_room_a;
                w_cons  = 1'b1;
            end else begin
                w_emit   = 1'b1;
                w_status = ifs_pkg::ST_MATCH;
            end
        end else if (r_phase == ifs_pkg::PH_ZERO && w_room_b && i_class.x) begin
            n_base  = ifs_pkg::BASE_HEX;
            n_phase = ifs_pkg::PH_DIGITS;
            w_take  = 1'b1;
            w_emit  = !w_room_a;
            w_cons  = 1'b1;
        end else begin
            n_base  = w_eff_base;
            n_phase = ifs_pkg::PH_DIGITS;
            if (w_dig_ok) begin
                w_digit = 1'b1;
                w_take  = 1'b1;
                w_emit  = !w_room_a;
                w_cons  = 1'b1;
            end else begin
                w_emit = 1'b1;
            end
        end
        if (w_emit) begin
            n_phase = ifs_pkg::PH_SKIP;
            n_base  = ifs_pkg::BASE_DEC;
            n_neg   = 1'b0;
        end
    end

    // Datapath next values and the result record.
    always_comb begin
        n_acc   = w_digit ? w_acc_md : r_acc;
        n_width = w_take ? w_width_inc : r_width;
        n_total = (w_take || w_ws) ? w_total_inc : r_total;

        w_info          = '0;
        w_info.status   = w_status;
        w_info.neg      = r_neg || (w_take && i_class.minus && r_phase == ifs_pkg::PH_SKIP);
        w_info.consumed = w_cons;
        w_info.count    = n_total;
        w_res           = {w_info, n_acc};

        if (w_emit) begin
            n_acc   = '0;
            n_width = '0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ifs_pkg::PH_SKIP;
            r_base  <= ifs_pkg::BASE_DEC;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_width <= '0;
            r_total <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_width <= n_width;
            r_total <= n_total;
        end
    end

    ifs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ifs_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && w_emit),
        .i_data  (w_res),
        .o_full  (w_oq_full),
        .i_pop   (i_pop),
        .o_data  (w_oq_data),
        .o_empty (o_empty)
    );

    // Sign and size are applied on the way out of the result queue.
    assign w_out_info   = ifs_pkg::t_res_info'(w_oq_data[RES_W-1:VALUE_BITS]);
    assign w_out_acc    = w_oq_data[VALUE_BITS-1:0];
    assign w_out_signed = w_out_info.neg ? ('0 - w_out_acc) : w_out_acc;

    assign o_status         = w_out_info.status;
    assign o_char_consumed  = w_out_info.consumed;
    assign o_chars_consumed = w_out_info.count;
    assign o_value          = (w_out_info.status == ifs_pkg::ST_OK)
                            ? (64'(w_out_signed) & ifs_pkg::size_mask(i_cfg.result_size))
                            : 64'd0;

    `IFS_ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, w_fire && w_emit, r_phase == ifs_pkg::PH_SKIP && r_total == '0)
    `IFS_ASSERT_SAME(a_skip_is_clean, i_clk, i_rst_n, r_phase == ifs_pkg::PH_SKIP, r_acc == '0 && r_width == '0)
    `IFS_ASSERT_SAME(a_input_fail_not_taken, i_clk, i_rst_n, w_fire && w_emit && w_status == ifs_pkg::ST_INPUT, !w_cons)

endmodule

>>> design/integer_field_scanner_core.sv
// Throughput: one character per cycle, sustained while results are popped.
// A result is written to the result queue when the character that ends the field
// leaves the character queue; the result ports show the head of the result queue.
// Reset is synchronous and active low; it empties both queues, restarts the field
// and restores the configuration registers. No clearing pass is needed.
module integer_field_scanner_core #(
    parameter int VALUE_BITS = ifs_pkg::VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ifs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ifs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ifs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_end_of_input,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_status,
    output logic [63:0]                    o_value,
    output logic                           o_char_consumed,
    output logic [15:0]                    o_chars_consumed
);
    ifs_pkg::t_cfg        r_cfg;
    ifs_pkg::t_char_class w_class;
    logic                 w_q_empty;
    logic                 w_q_pop;
    logic                 w_wr;
    logic [1:0]           w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind        <= '0;
            r_cfg.max_width   <= '0;
            r_cfg.result_size <= ifs_pkg::SIZE_32;
        end else if (w_wr) begin
            case (w_reg_idx)
                ifs_pkg::REG_KIND:  r_cfg.kind        <= pwdata[2:0];
                ifs_pkg::REG_MAXW:  r_cfg.max_width   <= pwdata[9:0];
                ifs_pkg::REG_RSIZE: r_cfg.result_size <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            ifs_pkg::REG_KIND:  prdata = ifs_pkg::CFG_DATA_W'(r_cfg.kind);
            ifs_pkg::REG_MAXW:  prdata = ifs_pkg::CFG_DATA_W'(r_cfg.max_width);
            ifs_pkg::REG_RSIZE: prdata = ifs_pkg::CFG_DATA_W'(r_cfg.result_size);
            default:            prdata = '0;
        endcase
    end

    ifs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_pop          (w_q_pop),
        .o_empty        (w_q_empty),
        .o_class        (w_class)
    );

    ifs_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (w_q_empty),
        .i_class          (w_class),
        .o_q_pop          (w_q_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_status         (o_status),
        .o_value          (o_value),
        .o_char_consumed  (o_char_consumed),
        .o_chars_consumed (o_chars_consumed)
    );

endmodule
